FILE: hdl/ppfe_pkg.sv
// Shared types, codes and arithmetic helpers for the pose-point factor evaluator.
package ppfe_pkg;

    localparam int unsigned VW = 32;
    localparam int unsigned OW = 33;
    localparam int unsigned PW = 66;
    localparam int unsigned FW = 50;
    localparam int unsigned SW = 53;
    localparam int unsigned CW = 48;

    localparam logic [1:0] CMD_POSE = 2'd0;
    localparam logic [1:0] CMD_LMK  = 2'd1;
    localparam logic [1:0] CMD_OBS  = 2'd2;

    localparam logic [2:0] REG_INFO_XX     = 3'd0;
    localparam logic [2:0] REG_INFO_XY     = 3'd1;
    localparam logic [2:0] REG_INFO_XZ     = 3'd2;
    localparam logic [2:0] REG_INFO_YY     = 3'd3;
    localparam logic [2:0] REG_INFO_YZ     = 3'd4;
    localparam logic [2:0] REG_INFO_ZZ     = 3'd5;
    localparam logic [2:0] REG_POINT_FIRST = 3'd6;

    // dot product schedule
    localparam logic [3:0] OP_RES_LAST = 4'd2;
    localparam logic [3:0] OP_W_FIRST  = 4'd3;
    localparam logic [3:0] OP_W_LAST   = 4'd5;
    localparam logic [3:0] OP_S        = 4'd6;
    localparam logic [3:0] OP_JAC_LAST = 4'd15;

    localparam logic [1:0] ROW_LAST = 2'd2;

    typedef struct packed {
        logic       load_pose;
        logic       load_lmk;
        logic       load_obs;
        logic       calc_diff;
        logic       mul;
        logic       acc;
        logic [3:0] op;
        logic [1:0] row;
    } t_dp_cmd;

    function automatic logic signed [VW-1:0] sat32(input logic signed [SW-1:0] x);
        logic signed [VW-1:0] y;
        if (x > 53'sd2147483647) begin
            y = 32'sh7FFF_FFFF;
        end else if (x < -53'sd2147483648) begin
            y = 32'sh8000_0000;
        end else begin
            y = x[VW-1:0];
        end
        return y;
    endfunction

    function automatic logic signed [FW-1:0] floor16(input logic signed [PW-1:0] p);
        return p[PW-1:16];
    endfunction

endpackage

FILE: hdl/ppfe_ctrl.sv
// Sequencer for loads, the dot-product schedule and result row emission.
module ppfe_ctrl import ppfe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_cmd,
    input  logic [1:0] i_row,
    output logic       o_stall,
    output logic       o_valid,
    input  logic       i_stall,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {S_IDLE, S_DIFF, S_MUL, S_ACC, S_EMIT} t_state;

    t_state     r_state;
    logic [3:0] r_op;
    logic [1:0] r_row;
    logic       r_valid;
    logic       acc_in;

    assign acc_in  = i_valid && (r_state == S_IDLE);
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

    always_comb begin
        o_cmd           = '0;
        o_cmd.load_pose = acc_in && (i_cmd == CMD_POSE) && (i_row <= ROW_LAST);
        o_cmd.load_lmk  = acc_in && (i_cmd == CMD_LMK);
        o_cmd.load_obs  = acc_in && (i_cmd == CMD_OBS);
        o_cmd.calc_diff = (r_state == S_DIFF);
        o_cmd.mul       = (r_state == S_MUL);
        o_cmd.acc       = (r_state == S_ACC);
        o_cmd.op        = r_op;
        o_cmd.row       = r_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= '0;
            r_row   <= '0;
            r_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (acc_in && (i_cmd == CMD_OBS)) begin
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_op    <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: r_state <= S_ACC;
                S_ACC: begin
                    if (r_op == OP_JAC_LAST) begin
                        r_row   <= '0;
                        r_valid <= 1'b1;
                        r_state <= S_EMIT;
                    end else begin
                        r_op    <= r_op + 4'd1;
                        r_state <= S_MUL;
                    end
                end
                S_EMIT: begin
                    if (!i_stall) begin
                        if (r_row == ROW_LAST) begin
                            r_valid <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_row <= r_row + 2'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_valid_only_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == S_EMIT)) else $error("result valid outside emit");
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_row <= ROW_LAST)) else $error("row out of range");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> o_stall) else $error("input open while busy");
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_valid) else $error("valid after reset");

endmodule

FILE: hdl/ppfe_dp.sv
// Stores, three shared multipliers, accumulate and result row assembly.
module ppfe_dp import ppfe_pkg::*; (
    input  logic                 i_clk,
    input  t_dp_cmd              i_cmd,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [VW-1:0]        i_cfg_data,
    input  logic                 i_rst_n,
    input  logic [1:0]           i_row,
    input  logic signed [VW-1:0] i_value_a,
    input  logic signed [VW-1:0] i_value_b,
    input  logic signed [VW-1:0] i_value_c,
    input  logic signed [VW-1:0] i_value_d,
    output logic signed [VW-1:0] o_residual,
    output logic signed [VW-1:0] o_jac [9],
    output logic [CW-1:0]        o_chi2,
    output logic                 o_last
);

    logic signed [VW-1:0] r_info [6];
    logic                 r_point_first;
    logic signed [VW-1:0] r_rot [3][4];
    logic signed [VW-1:0] r_lmk [3];
    logic signed [VW-1:0] r_z [3];
    logic signed [VW-1:0] r_d [3];
    logic signed [VW-1:0] r_r [3];
    logic signed [VW-1:0] r_w [3];
    logic signed [VW-1:0] r_jp [9];
    logic signed [SW-1:0] r_s;
    logic signed [PW-1:0] r_prod [3];

    logic signed [OW-1:0] opa [3];
    logic signed [OW-1:0] opb [3];
    logic signed [OW-1:0] hat [3][3];
    logic signed [SW-1:0] sum;
    logic [1:0]           oi;
    logic [1:0]           ok;
    logic [3:0]           jm;
    logic signed [VW-1:0] pose_out [6];
    logic signed [VW-1:0] pt_out [3];
    logic signed [SW-1:0] half;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_info[0]     <= 32'sd65536;
            r_info[1]     <= '0;
            r_info[2]     <= '0;
            r_info[3]     <= 32'sd65536;
            r_info[4]     <= '0;
            r_info[5]     <= 32'sd65536;
            r_point_first <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_INFO_XX:     r_info[0] <= i_cfg_data;
                REG_INFO_XY:     r_info[1] <= i_cfg_data;
                REG_INFO_XZ:     r_info[2] <= i_cfg_data;
                REG_INFO_YY:     r_info[3] <= i_cfg_data;
                REG_INFO_YZ:     r_info[4] <= i_cfg_data;
                REG_INFO_ZZ:     r_info[5] <= i_cfg_data;
                REG_POINT_FIRST: r_point_first <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // hat(l) as 33-bit entries so that negation cannot wrap
    always_comb begin
        hat[0][0] = '0;
        hat[0][1] = -{r_lmk[2][VW-1], r_lmk[2]};
        hat[0][2] = {r_lmk[1][VW-1], r_lmk[1]};
        hat[1][0] = {r_lmk[2][VW-1], r_lmk[2]};
        hat[1][1] = '0;
        hat[1][2] = -{r_lmk[0][VW-1], r_lmk[0]};
        hat[2][0] = -{r_lmk[1][VW-1], r_lmk[1]};
        hat[2][1] = {r_lmk[0][VW-1], r_lmk[0]};
        hat[2][2] = '0;
    end

    always_comb begin
        jm = i_cmd.op - 4'd7;
        oi = 2'd0;
        ok = 2'd0;
        if (i_cmd.op <= OP_RES_LAST) begin
            oi = i_cmd.op[1:0];
        end else if (i_cmd.op <= OP_W_LAST) begin
            oi = 2'(i_cmd.op - OP_W_FIRST);
        end else if (i_cmd.op > OP_S) begin
            unique case (jm)
                4'd0: begin oi = 2'd0; ok = 2'd0; end
                4'd1: begin oi = 2'd0; ok = 2'd1; end
                4'd2: begin oi = 2'd0; ok = 2'd2; end
                4'd3: begin oi = 2'd1; ok = 2'd0; end
                4'd4: begin oi = 2'd1; ok = 2'd1; end
                4'd5: begin oi = 2'd1; ok = 2'd2; end
                4'd6: begin oi = 2'd2; ok = 2'd0; end
                4'd7: begin oi = 2'd2; ok = 2'd1; end
                default: begin oi = 2'd2; ok = 2'd2; end
            endcase
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            opa[j] = '0;
            opb[j] = '0;
        end
        if (i_cmd.op <= OP_RES_LAST) begin
            for (int j = 0; j < 3; j++) begin
                opa[j] = {r_rot[j][oi][VW-1], r_rot[j][oi]};
                opb[j] = {r_d[j][VW-1], r_d[j]};
            end
        end else if (i_cmd.op <= OP_W_LAST) begin
            for (int j = 0; j < 3; j++) begin
                opb[j] = {r_r[j][VW-1], r_r[j]};
            end
            unique case (oi)
                2'd0: begin
                    opa[0] = {r_info[0][VW-1], r_info[0]};
                    opa[1] = {r_info[1][VW-1], r_info[1]};
                    opa[2] = {r_info[2][VW-1], r_info[2]};
                end
                2'd1: begin
                    opa[0] = {r_info[1][VW-1], r_info[1]};
                    opa[1] = {r_info[3][VW-1], r_info[3]};
                    opa[2] = {r_info[4][VW-1], r_info[4]};
                end
                default: begin
                    opa[0] = {r_info[2][VW-1], r_info[2]};
                    opa[1] = {r_info[4][VW-1], r_info[4]};
                    opa[2] = {r_info[5][VW-1], r_info[5]};
                end
            endcase
        end else if (i_cmd.op == OP_S) begin
            for (int j = 0; j < 3; j++) begin
                opa[j] = {r_r[j][VW-1], r_r[j]};
                opb[j] = {r_w[j][VW-1], r_w[j]};
            end
        end else begin
            for (int j = 0; j < 3; j++) begin
                opa[j] = {r_rot[j][oi][VW-1], r_rot[j][oi]};
                opb[j] = hat[j][ok];
            end
        end
    end

    assign sum = SW'(floor16(r_prod[0])) + SW'(floor16(r_prod[1]))
               + SW'(floor16(r_prod[2]));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pose) begin
            r_rot[i_row][0] <= i_value_a;
            r_rot[i_row][1] <= i_value_b;
            r_rot[i_row][2] <= i_value_c;
            r_rot[i_row][3] <= i_value_d;
        end
        if (i_cmd.load_lmk) begin
            r_lmk[0] <= i_value_a;
            r_lmk[1] <= i_value_b;
            r_lmk[2] <= i_value_c;
        end
        if (i_cmd.load_obs) begin
            r_z[0] <= i_value_a;
            r_z[1] <= i_value_b;
            r_z[2] <= i_value_c;
        end
        if (i_cmd.calc_diff) begin
            for (int j = 0; j < 3; j++) begin
                r_d[j] <= sat32(SW'(r_lmk[j]) - SW'(r_rot[j][3]));
            end
        end
        if (i_cmd.mul) begin
            for (int j = 0; j < 3; j++) begin
                r_prod[j] <= PW'(opa[j]) * PW'(opb[j]);
            end
        end
        if (i_cmd.acc) begin
            if (i_cmd.op <= OP_RES_LAST) begin
                r_r[oi] <= sat32(sum - SW'(r_z[oi]));
            end else if (i_cmd.op <= OP_W_LAST) begin
                r_w[oi] <= sat32(sum);
            end else if (i_cmd.op == OP_S) begin
                r_s <= sum;
            end else begin
                r_jp[jm] <= sat32(sum);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pose_out[k]     = r_jp[3 * i_cmd.row + k];
            pose_out[3 + k] = sat32(-SW'(r_rot[k][i_cmd.row]));
            pt_out[k]       = r_rot[k][i_cmd.row];
        end
        for (int k = 0; k < 9; k++) begin
            o_jac[k] = '0;
        end
        if (r_point_first) begin
            for (int k = 0; k < 3; k++) o_jac[k] = pt_out[k];
            for (int k = 0; k < 6; k++) o_jac[3 + k] = pose_out[k];
        end else begin
            for (int k = 0; k < 6; k++) o_jac[k] = pose_out[k];
            for (int k = 0; k < 3; k++) o_jac[6 + k] = pt_out[k];
        end
        o_residual = r_r[i_cmd.row];
        o_last     = (i_cmd.row == ROW_LAST);
        half       = r_s >>> 1;
        if (!o_last || r_s < 0) begin
            o_chi2 = '0;
        end else if (half > SW'(48'hFFFF_FFFF_FFFF)) begin
            o_chi2 = '1;
        end else begin
            o_chi2 = half[CW-1:0];
        end
    end

endmodule

FILE: hdl/pose_point_factor_eval.sv
// Top level of the pose-to-landmark factor evaluator.
// Input channel: i_valid / o_stall carry load and observation transactions.
//   cmd 0 writes pose row [R|t] (row 3 ignored), cmd 1 the landmark, cmd 2
//   an observation z that starts evaluation; cmd 3 is ignored.
// Loads produce nothing.
// An observation gives three result transactions on o_valid / i_stall, one
//   per residual component, with the Jacobian row; chi2 and last on the third.
// After the observation is taken, l - t is formed first; then 16 dot
//   products each take a multiply state and an accumulate state on three
//   shared 33x33 multipliers.
// o_stall stays high from an observation until its last result is taken.
// A stalled receiver holds the current result row steady.
// Reset returns W to identity, point_first to 0 and the sequencer to idle;
//   pose and landmark stores hold nothing valid until loaded.
// Configuration writes are taken at any time but only while idle are safe.
module pose_point_factor_eval import ppfe_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_cmd,
    input  logic [1:0]           i_row,
    input  logic signed [VW-1:0] i_value_a,
    input  logic signed [VW-1:0] i_value_b,
    input  logic signed [VW-1:0] i_value_c,
    input  logic signed [VW-1:0] i_value_d,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [VW-1:0] o_residual,
    output logic signed [VW-1:0] o_jac_0,
    output logic signed [VW-1:0] o_jac_1,
    output logic signed [VW-1:0] o_jac_2,
    output logic signed [VW-1:0] o_jac_3,
    output logic signed [VW-1:0] o_jac_4,
    output logic signed [VW-1:0] o_jac_5,
    output logic signed [VW-1:0] o_jac_6,
    output logic signed [VW-1:0] o_jac_7,
    output logic signed [VW-1:0] o_jac_8,
    output logic [CW-1:0]        o_chi2,
    output logic                 o_last,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [VW-1:0]        i_cfg_data
);

    t_dp_cmd              dp_cmd;
    logic signed [VW-1:0] jac [9];

    ppfe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .i_row   (i_row),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (dp_cmd)
    );

    ppfe_dp u_dp (
        .i_clk      (i_clk),
        .i_cmd      (dp_cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rst_n    (i_rst_n),
        .i_row      (i_row),
        .i_value_a  (i_value_a),
        .i_value_b  (i_value_b),
        .i_value_c  (i_value_c),
        .i_value_d  (i_value_d),
        .o_residual (o_residual),
        .o_jac      (jac),
        .o_chi2     (o_chi2),
        .o_last     (o_last)
    );

    assign o_jac_0 = jac[0];
    assign o_jac_1 = jac[1];
    assign o_jac_2 = jac[2];
    assign o_jac_3 = jac[3];
    assign o_jac_4 = jac[4];
    assign o_jac_5 = jac[5];
    assign o_jac_6 = jac[6];
    assign o_jac_7 = jac[7];
    assign o_jac_8 = jac[8];

endmodule

FILE: verif/pose_point_factor_eval_tb.sv
// Testbench for the pose-to-landmark factor evaluator: predicts and checks every result row.
`timescale 1ns / 1ps

module pose_point_factor_eval_tb;
    import ppfe_pkg::*;

    typedef struct packed {
        logic signed [31:0]      residual;
        logic [8:0][31:0]        jac;
        logic [47:0]             chi2;
        logic                    last;
    } t_factor_row;

    class factor_scoreboard;
        longint      info[6];
        bit          point_first;
        longint      pose[12];
        longint      lmk[3];
        t_factor_row rows_q[$];
        int          errors;

        function new();
            info = '{65536, 0, 0, 65536, 0, 65536};
            point_first = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] data);
            if (idx == REG_POINT_FIRST) begin
                point_first = data[0];
            end else if (idx <= REG_INFO_ZZ) begin
                info[idx] = longint'($signed(data));
            end
        endfunction

        function longint fl(longint p);
            return p >>> 16;
        endfunction

        function longint clip(longint x);
            if (x > 64'sd2147483647) return 64'sd2147483647;
            if (x < -64'sd2147483648) return -64'sd2147483648;
            return x;
        endfunction

        function longint dot(longint a0, longint b0, longint a1, longint b1,
                             longint a2, longint b2);
            return fl(a0 * b0) + fl(a1 * b1) + fl(a2 * b2);
        endfunction

        function longint rot(int i, int j);
            return pose[i * 4 + j];
        endfunction

        function void note_input(logic [1:0] cmd, logic [1:0] row, logic [31:0] a,
                                 logic [31:0] b, logic [31:0] c, logic [31:0] d);
            longint z[3], dd[3], r[3], w[3], hat[3][3], wm[3][3], pz[6], pt[3];
            longint s, chi;
            t_factor_row fr;
            z = '{longint'($signed(a)), longint'($signed(b)), longint'($signed(c))};
            case (cmd)
                CMD_POSE: begin
                    if (row <= ROW_LAST) begin
                        pose[row * 4]     = z[0];
                        pose[row * 4 + 1] = z[1];
                        pose[row * 4 + 2] = z[2];
                        pose[row * 4 + 3] = longint'($signed(d));
                    end
                end
                CMD_LMK: lmk = z;
                CMD_OBS: begin
                    for (int i = 0; i < 3; i++) dd[i] = clip(lmk[i] - rot(i, 3));
                    for (int i = 0; i < 3; i++)
                        r[i] = clip(dot(rot(0, i), dd[0], rot(1, i), dd[1],
                                        rot(2, i), dd[2]) - z[i]);
                    hat = '{'{0, -lmk[2], lmk[1]}, '{lmk[2], 0, -lmk[0]},
                            '{-lmk[1], lmk[0], 0}};
                    wm = '{'{info[0], info[1], info[2]}, '{info[1], info[3], info[4]},
                           '{info[2], info[4], info[5]}};
                    for (int i = 0; i < 3; i++)
                        w[i] = clip(dot(wm[i][0], r[0], wm[i][1], r[1], wm[i][2], r[2]));
                    s = dot(r[0], w[0], r[1], w[1], r[2], w[2]);
                    chi = (s < 0) ? 0 : (s >>> 1);
                    if (chi > 64'sh0000_FFFF_FFFF_FFFF) chi = 64'sh0000_FFFF_FFFF_FFFF;
                    for (int i = 0; i < 3; i++) begin
                        for (int k = 0; k < 3; k++) begin
                            pz[k] = clip(dot(rot(0, i), hat[0][k], rot(1, i), hat[1][k],
                                             rot(2, i), hat[2][k]));
                            pz[3 + k] = clip(-rot(k, i));
                            pt[k] = rot(k, i);
                        end
                        fr.residual = r[i][31:0];
                        for (int k = 0; k < 6; k++)
                            fr.jac[(point_first ? 3 : 0) + k] = pz[k][31:0];
                        for (int k = 0; k < 3; k++)
                            fr.jac[(point_first ? 0 : 6) + k] = pt[k][31:0];
                        fr.chi2 = (i == 2) ? chi[47:0] : 48'd0;
                        fr.last = (i == 2);
                        rows_q = {rows_q, fr};
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_factor_row got);
            t_factor_row exp_row;
            if (rows_q.size() == 0) begin
                $display("%0t unexpected result row %h", $time, got);
                errors++;
                return;
            end
            exp_row = rows_q.pop_front();
            if (got.residual !== exp_row.residual) begin
                $display("%0t residual exp %h got %h", $time, exp_row.residual, got.residual);
                errors++;
            end
            for (int k = 0; k < 9; k++)
                if (got.jac[k] !== exp_row.jac[k]) begin
                    $display("%0t jac_%0d exp %h got %h", $time, k, exp_row.jac[k], got.jac[k]);
                    errors++;
                end
            if (got.chi2 !== exp_row.chi2) begin
                $display("%0t chi2 exp %h got %h", $time, exp_row.chi2, got.chi2);
                errors++;
            end
            if (got.last !== exp_row.last) begin
                $display("%0t last exp %b got %b", $time, exp_row.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0, i_valid = 0, i_stall = 0, i_cfg_we = 0;
    logic [1:0] i_cmd = CMD_POSE, i_row = 0;
    logic signed [31:0] i_value_a = 0, i_value_b = 0, i_value_c = 0, i_value_d = 0;
    logic [2:0] i_cfg_idx = REG_INFO_XX;
    logic [31:0] i_cfg_data = 0;
    logic o_stall, o_valid, o_last;
    logic signed [31:0] o_residual, o_jac_0, o_jac_1, o_jac_2, o_jac_3, o_jac_4;
    logic signed [31:0] o_jac_5, o_jac_6, o_jac_7, o_jac_8;
    logic [47:0] o_chi2;

    factor_scoreboard sb = new();
    bit  quiet = 0;
    bit  hold_req = 0;
    int  cycles = 0;

    pose_point_factor_eval i_dut (.*);

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(t_factor_row'{o_residual, {o_jac_8, o_jac_7, o_jac_6, o_jac_5,
                              o_jac_4, o_jac_3, o_jac_2, o_jac_1, o_jac_0}, o_chi2, o_last});

    // result side back-pressure, with one long hold when asked
    initial begin
        int burst;
        burst = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1;
                hold_req = 0;
                repeat (300) @(negedge i_clk);
            end else if (quiet) begin
                i_stall <= 0;
            end else if (burst > 0) begin
                burst--;
            end else if ($urandom_range(0, 3) == 0) begin
                i_stall <= 1;
                burst = $urandom_range(0, 7);
            end else begin
                i_stall <= 0;
                burst = $urandom_range(0, 6);
            end
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 131072) - 65536;
            1: return $urandom_range(0, 2 * 6553600) - 6553600;
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send(logic [1:0] cmd, logic [1:0] row, logic [31:0] a, logic [31:0] b,
                        logic [31:0] c, logic [31:0] d);
        int gap;
        @(negedge i_clk);
        i_valid <= 1;
        i_cmd <= cmd;
        i_row <= row;
        i_value_a <= a;
        i_value_b <= b;
        i_value_c <= c;
        i_value_d <= d;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(cmd, row, a, b, c, d);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            i_valid <= 0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_rand(logic [1:0] cmd, logic [1:0] row);
        send(cmd, row, pick_value(), pick_value(), pick_value(), pick_value());
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 0;
        while (sb.rows_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        sb.set_reg(idx, data);
    endtask

    task automatic write_info(logic [31:0] xx, logic [31:0] xy, logic [31:0] xz,
                              logic [31:0] yy, logic [31:0] yz, logic [31:0] zz, bit pf);
        write_reg(REG_INFO_XX, xx);
        write_reg(REG_INFO_XY, xy);
        write_reg(REG_INFO_XZ, xz);
        write_reg(REG_INFO_YY, yy);
        write_reg(REG_INFO_YZ, yz);
        write_reg(REG_INFO_ZZ, zz);
        write_reg(REG_POINT_FIRST, {31'd0, pf});
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    // mostly full factor sequences, some stray loads and ignored transactions
    task automatic random_phase(int n);
        int sent;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 9) < 7) begin
                for (int k = 0; k < 3; k++)
                    if ($urandom_range(0, 3) != 0) begin
                        send_rand(CMD_POSE, 2'($urandom_range(0, 2)));
                        sent++;
                    end
                if ($urandom_range(0, 1)) begin
                    send_rand(CMD_LMK, 2'($urandom));
                    sent++;
                end
                send_rand(CMD_OBS, 2'($urandom));
                sent++;
            end else begin
                case ($urandom_range(0, 3))
                    0: send_rand(2'd3, 2'($urandom));
                    1: send_rand(CMD_POSE, 2'd3);
                    2: send_rand(CMD_LMK, 2'($urandom));
                    default: send_rand(CMD_OBS, 2'($urandom));
                endcase
                sent++;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // identity pose, then extremes of every field
        send(CMD_POSE, 0, 32'h0001_0000, 0, 0, 32'h0002_0000);
        send(CMD_POSE, 1, 0, 32'h0001_0000, 0, 0);
        send(CMD_POSE, 2, 0, 0, 32'h0001_0000, 32'hFFFF_0000);
        send(CMD_LMK, 0, 32'h0003_0000, 32'h0001_8000, 32'hFFFE_0000, 0);
        send(CMD_OBS, 0, 32'h0000_8000, 0, 32'hFFFF_0000, 0);
        send(CMD_POSE, 3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send(2'd3, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(CMD_OBS, 1, 0, 0, 0, 32'h1234_5678);
        send(CMD_POSE, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send(CMD_POSE, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send(CMD_POSE, 2, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send(CMD_LMK, 2, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555);
        send(CMD_OBS, 3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA);
        send(CMD_LMK, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send(CMD_OBS, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        send(CMD_OBS, 0, 0, 0, 0, 0);
        random_phase(60);
        drain();

        write_info($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1);
        hold_req = 1;
        random_phase(60);
        drain();

        write_info(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        random_phase(50);
        drain();

        write_info(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 1);
        random_phase(40);
        drain();

        write_info(32'h0004_0000, 32'h0000_4000, 32'hFFFF_C000, 32'h0002_0000,
                   32'h0000_2000, 32'h0010_0000, 0);
        random_phase(40);
        quiet = 1;
        random_phase(40);
        drain();

        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
